/* sv/ale_pkg.sv */
// Package for the array list engine: command, status and datapath op codes, payload types.
// No dependencies.
package ale_pkg;
  localparam int unsigned DefDepth = 64;

  // datapath op codes issued by the controller
  localparam logic [3:0] OpNone  = 4'd0;
  localparam logic [3:0] OpRdI   = 4'd1;  // read at i
  localparam logic [3:0] OpRdJ   = 4'd2;  // read at j, capture rd into a
  localparam logic [3:0] OpWrI   = 4'd3;  // write b at i
  localparam logic [3:0] OpWrJ   = 4'd4;  // write a at j, j++
  localparam logic [3:0] OpWrVal = 4'd5;  // write data_value at i
  localparam logic [3:0] OpSetI  = 4'd6;  // load i and j for a shift walk
  localparam logic [3:0] OpIncI  = 4'd7;  // i++, j++
  localparam logic [3:0] OpDecI  = 4'd8;  // i--, j--
  localparam logic [3:0] OpIncJ  = 4'd9;  // j++
  localparam logic [3:0] OpNextI = 4'd10; // i++, j <= i+2
  localparam logic [3:0] OpCnt0  = 4'd11;
  localparam logic [3:0] OpCntUp = 4'd12;
  localparam logic [3:0] OpCntDn = 4'd13;
  localparam logic [3:0] OpCapB  = 4'd14; // capture rd into b
  localparam logic [3:0] OpI0    = 4'd15; // i <= 0, j <= 1

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SORT   = 3'd4,
    CMD_SEARCH = 3'd5,
    CMD_DUMP   = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADIDX   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [6:0]         position;
    logic signed [31:0] data_value;
    logic               descending;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_position;
    logic signed [31:0] element;
    logic               has_element;
    logic               last;
    logic [6:0]         length;
  } rsp_t;
endpackage

/* sv/ale_if.sv */
// Valid/ready channel interface carrying one payload of type T.
// Depends on ale_pkg for payload types at instantiation.
interface ale_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/ale_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module ale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* sv/ale_datapath.sv */
// Datapath: element store, count, index and operand registers, compare and request register.
// Depends on ale_pkg and ale_ram.
module ale_datapath import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ld_req_i,
  input  req_t        req_i,
  input  logic [3:0]  op_i,
  output logic [6:0]  cnt_o,
  output logic [6:0]  i_o,
  output logic [6:0]  j_o,
  output logic        match_o,
  output logic        swap_o,
  output req_t        req_o,
  output logic [31:0] rd_o
);
  req_t        req_q;
  logic [6:0]  cnt_q, i_q, j_q;
  logic [31:0] a_q, b_q, rd;
  logic        we;
  logic [6:0]  addr;
  logic [31:0] wdata;

  always_comb begin
    we = 1'b0;
    addr = i_q;
    wdata = b_q;
    unique case (op_i)
      OpRdJ:   addr = j_q;
      OpWrI:   we = 1'b1;
      OpWrJ:   begin we = 1'b1; addr = j_q; wdata = a_q; end
      OpWrVal: begin we = 1'b1; wdata = req_q.data_value; end
      default: ;
    endcase
  end

  ale_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr[AddrW-1:0]), .wdata_i(wdata), .rdata_o(rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (op_i)
        OpCnt0:  cnt_q <= '0;
        OpCntUp: cnt_q <= cnt_q + 7'd1;
        OpCntDn: cnt_q <= cnt_q - 7'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_req_i) req_q <= req_i;
    unique case (op_i)
      // delete walks up from position, insert and append start at count
      OpSetI: begin
        if (req_q.command == CMD_DELETE) begin
          i_q <= req_q.position;
          j_q <= req_q.position + 7'd1;
        end else begin
          i_q <= cnt_q;
          j_q <= cnt_q - 7'd1;
        end
      end
      OpIncI: begin i_q <= i_q + 7'd1; j_q <= j_q + 7'd1; end
      OpDecI: begin i_q <= i_q - 7'd1; j_q <= j_q - 7'd1; end
      OpIncJ: j_q <= j_q + 7'd1;
      OpWrJ:  j_q <= j_q + 7'd1;
      OpNextI: begin i_q <= i_q + 7'd1; j_q <= i_q + 7'd2; end
      OpRdJ:  a_q <= rd;
      OpCapB: b_q <= rd;
      OpI0:   begin i_q <= '0; j_q <= 7'd1; end
      default: ;
    endcase
  end

  // a holds element i, b holds element j during sort compare
  assign match_o = (rd == req_q.data_value);
  assign swap_o  = req_q.descending ? ($signed(b_q) > $signed(a_q))
                                    : ($signed(a_q) > $signed(b_q));
  assign cnt_o = cnt_q;
  assign i_o   = i_q;
  assign j_o   = j_q;
  assign req_o = req_q;
  assign rd_o  = rd;
endmodule

/* sv/ale_ctrl.sv */
// Controller state machine for the array list engine; issues datapath ops.
// Depends on ale_pkg.
module ale_ctrl import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        rsp_o,
  output logic        ld_req_o,
  output logic [3:0]  op_o,
  input  logic [6:0]  cnt_i,
  input  logic [6:0]  i_i,
  input  logic [6:0]  j_i,
  input  logic        match_i,
  input  logic        swap_i,
  input  req_t        req_i,
  input  logic [31:0] rd_i
);
  localparam logic [6:0] DepthC = 7'(Depth);

  localparam logic [4:0] SIdle = 5'd0, SDec = 5'd1, SInsRd = 5'd2, SInsWr = 5'd3,
    SDelRd = 5'd4, SShCap = 5'd5, SShWr = 5'd6, SShMov = 5'd7, SSrRd = 5'd8,
    SSrCmp = 5'd9, SDmRd = 5'd10, SDmOut = 5'd11, SSoRdI = 5'd12, SSoRdJ = 5'd13,
    SSoCmp = 5'd14, SSoWr = 5'd15, SSoCap = 5'd16, SResp = 5'd17;

  logic [4:0] state_q, state_d;
  rsp_t       rsp_q, rsp_d;
  logic       ov_q, ov_d;
  logic       load;

  // hold off new commands until the previous result has left
  assign in_ready_o  = (state_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign rsp_o       = rsp_q;
  assign ld_req_o    = in_valid_i && in_ready_o;

  function automatic rsp_t mk(logic [1:0] st, logic [6:0] len);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    r.length = len;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    ov_d = ov_q && !out_ready_i;
    op_o = OpNone;
    load = 1'b0;
    unique case (state_q)
      SIdle: if (ld_req_o) state_d = SDec;
      SDec: begin
        unique case (cmd_e'(req_i.command))
          CMD_CLEAR: begin op_o = OpCnt0; rsp_d = mk(ST_OK, 7'd0); load = 1'b1; end
          CMD_APPEND: begin
            if (cnt_i >= DepthC) begin
              rsp_d = mk(ST_FULL, cnt_i); load = 1'b1;
            end else begin
              op_o = OpSetI; state_d = SInsWr; // i <= count
            end
          end
          CMD_INSERT: begin
            if (req_i.position > cnt_i) begin rsp_d = mk(ST_BADIDX, cnt_i); load = 1'b1; end
            else if (cnt_i >= DepthC) begin rsp_d = mk(ST_FULL, cnt_i); load = 1'b1; end
            else begin op_o = OpSetI; state_d = SInsRd; end
          end
          CMD_DELETE: begin
            if (req_i.position >= cnt_i) begin rsp_d = mk(ST_BADIDX, cnt_i); load = 1'b1; end
            else begin op_o = OpSetI; state_d = SDelRd; end
          end
          CMD_SORT: begin op_o = OpI0; state_d = SSoRdI; end
          CMD_SEARCH: begin op_o = OpI0; state_d = SSrRd; end
          CMD_DUMP: begin op_o = OpI0; state_d = SDmRd; end
          default: begin rsp_d = mk(ST_OK, cnt_i); load = 1'b1; end
        endcase
      end
      // shift up: i walks from count down to position, j = i - 1
      SInsRd: begin
        if (i_i == req_i.position) state_d = SInsWr;
        else begin op_o = OpRdJ; state_d = SShCap; end
      end
      SInsWr: begin op_o = OpWrVal; state_d = SResp; end
      // shift down: i walks up from position, j = i + 1
      SDelRd: begin
        if (j_i >= cnt_i) begin op_o = OpCntDn; state_d = SResp; end
        else begin op_o = OpRdJ; state_d = SShCap; end
      end
      // shared shift step: capture element j, write it at i, advance
      SShCap: begin op_o = OpCapB; state_d = SShWr; end
      SShWr: begin op_o = OpWrI; state_d = SShMov; end
      SShMov: begin
        if (req_i.command == CMD_INSERT) begin op_o = OpDecI; state_d = SInsRd; end
        else begin op_o = OpIncI; state_d = SDelRd; end
      end
      SSrRd: begin
        if (i_i >= cnt_i) begin rsp_d = mk(ST_NOTFOUND, cnt_i); load = 1'b1; end
        else begin op_o = OpRdI; state_d = SSrCmp; end
      end
      SSrCmp: begin
        if (match_i) begin
          rsp_d = mk(ST_OK, cnt_i); rsp_d.found_position = i_i[5:0]; load = 1'b1;
        end else begin op_o = OpIncI; state_d = SSrRd; end
      end
      SDmRd: begin
        if (cnt_i == 7'd0) begin rsp_d = mk(ST_OK, cnt_i); load = 1'b1; end
        else if (!ov_q || out_ready_i) begin op_o = OpRdI; state_d = SDmOut; end
      end
      SDmOut: begin
        rsp_d = mk(ST_OK, cnt_i);
        rsp_d.element = rd_i;
        rsp_d.has_element = 1'b1;
        rsp_d.last = (i_i + 7'd1 == cnt_i);
        ov_d = 1'b1;
        op_o = OpIncI;
        state_d = rsp_d.last ? SIdle : SDmRd;
      end
      SSoRdI: begin
        if (i_i >= cnt_i) begin rsp_d = mk(ST_OK, cnt_i); load = 1'b1; end
        else if (j_i >= cnt_i) op_o = OpNextI;
        else begin op_o = OpRdI; state_d = SSoRdJ; end
      end
      // rd holds element i here; capture it into a and read element j
      SSoRdJ: begin op_o = OpRdJ; state_d = SSoCmp; end
      SSoCmp: begin op_o = OpCapB; state_d = SSoWr; end
      SSoWr: begin
        if (swap_i) begin op_o = OpWrI; state_d = SSoCap; end
        else begin op_o = OpIncJ; state_d = SSoRdI; end
      end
      SSoCap: begin op_o = OpWrJ; state_d = SSoRdI; end
      SResp: begin
        if (req_i.command == CMD_DELETE || req_i.command == CMD_SORT) begin
          rsp_d = mk(ST_OK, cnt_i); load = 1'b1;
        end else begin
          op_o = OpCntUp; rsp_d = mk(ST_OK, cnt_i + 7'd1); load = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
    if (load) begin
      ov_d = 1'b1;
      state_d = SIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end
endmodule

/* sv/array_list_engine.sv */
// Array list engine: a packed list of signed 32-bit values with a count.
// Channel in_if carries a command with position, data_value and descending.
// Channel out_if carries results: status, found_position, element,
// has_element, last and length. Every command yields one result with last
// set, except dump, which yields one result per element (last on the final
// one) or a single empty result for an empty list.
// Commands are taken one at a time: in_if.ready is high only while idle with
// the result register empty, so the next command can be accepted in the cycle
// after the final result transaction. Clear, the unused code and errors
// respond straight from decode; the other commands walk the store through
// the single RAM port.
// Reset empties the list; store contents are undefined until written.
// A stalled receiver holds the result register; dump waits on it per element.
// Depends on ale_pkg, ale_if, ale_ram, ale_datapath and ale_ctrl.
module array_list_engine import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input logic clk_i,
  input logic rst_ni,
  ale_if.sink   in_if,
  ale_if.source out_if
);
  logic        ld_req, match, swap;
  logic [3:0]  op;
  logic [6:0]  cnt, i, j;
  logic [31:0] rd;
  req_t        req;

  ale_datapath #(.Depth(Depth)) u_dp (
    .clk_i, .rst_ni, .ld_req_i(ld_req), .req_i(in_if.payload), .op_i(op),
    .cnt_o(cnt), .i_o(i), .j_o(j), .match_o(match), .swap_o(swap),
    .req_o(req), .rd_o(rd)
  );

  ale_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .rsp_o(out_if.payload), .ld_req_o(ld_req), .op_o(op), .cnt_i(cnt),
    .i_i(i), .j_i(j), .match_i(match), .swap_i(swap), .req_i(req), .rd_i(rd)
  );
endmodule

/* dv/array_list_engine_test.sv */
// Testbench for array_list_engine: directed table, fill and hold-off tests, then random command streams.
// Results are checked against an in-bench list predictor or fixed expected results.
// Depends on ale_pkg, ale_if and the array_list_engine RTL.
module array_list_engine_test;
  import ale_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ale_if #(.T(req_t)) cmd_ch ();
  ale_if #(.T(rsp_t)) rsp_ch ();

  array_list_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_ch.sink),
    .out_if (rsp_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the list
  logic signed [31:0] list_q[$];

  rsp_t expected_rsp_q[$];
  int   mismatch_cnt;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   recv_hold_cycles;

  typedef struct {
    req_t req;
    bit   has_fixed;
    rsp_t fixed;
  } row_t;

  row_t rows[$];

  function automatic rsp_t mk_rsp(status_e st, int unsigned fp, logic signed [31:0] el,
                                  logic he, logic lst, int unsigned len);
    rsp_t r;
    r.status         = st;
    r.found_position = fp[5:0];
    r.element        = el;
    r.has_element    = he;
    r.last           = lst;
    r.length         = len[6:0];
    return r;
  endfunction

  // Apply one command to the shadow list and queue its results
  task automatic predict_list_cmd(input req_t req);
    int n;
    logic signed [31:0] t;
    bit hit;
    n = list_q.size();
    case (cmd_e'(req.command))
      CMD_CLEAR: begin
        list_q.delete();
        expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, 0));
      end
      CMD_APPEND: begin
        if (n >= DefDepth) begin
          expected_rsp_q.push_back(mk_rsp(ST_FULL, 0, 0, 0, 1, n));
        end else begin
          list_q.push_back(req.data_value);
          expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, n + 1));
        end
      end
      CMD_INSERT: begin
        if (req.position > n) begin
          expected_rsp_q.push_back(mk_rsp(ST_BADIDX, 0, 0, 0, 1, n));
        end else if (n >= DefDepth) begin
          expected_rsp_q.push_back(mk_rsp(ST_FULL, 0, 0, 0, 1, n));
        end else begin
          list_q.insert(req.position, req.data_value);
          expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, n + 1));
        end
      end
      CMD_DELETE: begin
        if (req.position >= n) begin
          expected_rsp_q.push_back(mk_rsp(ST_BADIDX, 0, 0, 0, 1, n));
        end else begin
          list_q.delete(req.position);
          expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, n - 1));
        end
      end
      CMD_SORT: begin
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            if (req.descending ? (list_q[j] > list_q[i]) : (list_q[i] > list_q[j])) begin
              t = list_q[i];
              list_q[i] = list_q[j];
              list_q[j] = t;
            end
          end
        end
        expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, n));
      end
      CMD_SEARCH: begin
        hit = 1'b0;
        for (int i = 0; i < n && !hit; i++) begin
          if (list_q[i] == req.data_value) begin
            hit = 1'b1;
            expected_rsp_q.push_back(mk_rsp(ST_OK, i, 0, 0, 1, n));
          end
        end
        if (!hit) expected_rsp_q.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 0, 1, n));
      end
      CMD_DUMP: begin
        if (n == 0) expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, 0));
        for (int i = 0; i < n; i++) begin
          expected_rsp_q.push_back(mk_rsp(ST_OK, 0, list_q[i], 1, i + 1 == n, n));
        end
      end
      default: begin
        expected_rsp_q.push_back(mk_rsp(ST_OK, 0, 0, 0, 1, n));
      end
    endcase
  endtask

  function automatic req_t mk_req(cmd_e c, int unsigned p, logic [31:0] v, int unsigned d);
    req_t r;
    r.command    = c;
    r.position   = p[6:0];
    r.data_value = v;
    r.descending = d[0];
    return r;
  endfunction

  task automatic add_row(cmd_e c, int unsigned p, logic [31:0] v, int unsigned d,
                         bit fx = 0, rsp_t f = '0);
    row_t r;
    r.req       = mk_req(c, p, v, d);
    r.has_fixed = fx;
    r.fixed     = f;
    rows.push_back(r);
  endtask

  // Offer one transaction at the falling edge and hold until it is accepted
  task automatic send_cmd(input req_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= req;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_cmd(input req_t req);
    predict_list_cmd(req);
    send_cmd(req);
  endtask

  task automatic drain;
    cmd_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req(int n, bit fill);
    int unsigned roll;
    logic [31:0] v;
    roll = $urandom_range(99);
    v = (n > 0 && $urandom_range(1)) ? list_q[$urandom_range(n - 1)] : rand_value();
    if (fill && roll < 60) return mk_req(CMD_APPEND, $urandom_range(127), v, $urandom_range(1));
    if (roll < 30) return mk_req(CMD_APPEND, $urandom_range(127), v, $urandom_range(1));
    if (roll < 48) return mk_req(CMD_INSERT, $urandom_range(1) ? $urandom_range(n) :
                                 $urandom_range(127), v, $urandom_range(1));
    if (roll < 62) return mk_req(CMD_DELETE, $urandom_range(1) ? $urandom_range(n) :
                                 $urandom_range(127), v, $urandom_range(1));
    if (roll < 72) return mk_req(CMD_SEARCH, $urandom_range(127), v, $urandom_range(1));
    if (roll < 79) return mk_req(CMD_SORT, $urandom_range(127), v, $urandom_range(1));
    if (roll < 90) return mk_req(CMD_DUMP, $urandom_range(127), v, $urandom_range(1));
    if (roll < 94) return mk_req(CMD_NOP, $urandom_range(127), v, $urandom_range(1));
    return mk_req(CMD_CLEAR, $urandom_range(127), v, $urandom_range(1));
  endfunction

  // Receiver: random stalls, an optional long hold-off, and the result check
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (expected_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_rsp_q.pop_front();
        if (got.status !== want.status || got.found_position !== want.found_position ||
            got.element !== want.element || got.has_element !== want.has_element ||
            got.last !== want.last || got.length !== want.length) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL array_list_engine");
    $finish;
  end

  initial begin
    req_t req;
    int n;
    cmd_ch.valid     = 1'b0;
    cmd_ch.payload   = '0;
    rsp_ch.ready     = 1'b0;
    mismatch_cnt     = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    add_row(CMD_DUMP, 0, 0, 0, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 0));
    add_row(CMD_DELETE, 0, 0, 0, 1, mk_rsp(ST_BADIDX, 0, 0, 0, 1, 0));
    add_row(CMD_INSERT, 1, 5, 0, 1, mk_rsp(ST_BADIDX, 0, 0, 0, 1, 0));
    add_row(CMD_SEARCH, 0, 5, 0, 1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 1, 0));
    add_row(CMD_APPEND, 0, 32'h8000_0000, 0, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 1));
    add_row(CMD_APPEND, 127, 32'h7fff_ffff, 1, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 2));
    add_row(CMD_INSERT, 0, 32'hffff_ffff, 0);
    add_row(CMD_INSERT, 3, 0, 1);
    add_row(CMD_INSERT, 1, 32'h5555_5555, 0);
    add_row(CMD_DUMP, 0, 0, 0);
    add_row(CMD_SORT, 0, 0, 0);
    add_row(CMD_DUMP, 0, 0, 0);
    add_row(CMD_SORT, 0, 0, 1);
    add_row(CMD_DUMP, 0, 0, 0);
    add_row(CMD_SEARCH, 0, 32'h8000_0000, 0);
    add_row(CMD_DELETE, 5, 0, 0, 1, mk_rsp(ST_BADIDX, 0, 0, 0, 1, 5));
    add_row(CMD_DELETE, 4, 0, 0);
    add_row(CMD_DELETE, 0, 0, 0);
    add_row(CMD_NOP, 127, 32'haaaa_aaaa, 1, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 3));
    add_row(CMD_CLEAR, 0, 0, 0, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 0));
    add_row(CMD_DUMP, 0, 0, 0, 1, mk_rsp(ST_OK, 0, 0, 0, 1, 0));
    foreach (rows[i]) begin
      if (rows[i].has_fixed) begin
        expected_rsp_q.push_back(rows[i].fixed);
        predict_list_cmd(rows[i].req);
        void'(expected_rsp_q.pop_back());
        send_cmd(rows[i].req);
      end else begin
        run_cmd(rows[i].req);
      end
    end
    drain();

    // fill to the limit, then hit full on append and insert
    for (int i = 0; i < DefDepth; i++) run_cmd(mk_req(CMD_APPEND, 0, rand_value(), 0));
    run_cmd(mk_req(CMD_APPEND, 0, 1, 0));
    run_cmd(mk_req(CMD_INSERT, 64, 1, 0));
    run_cmd(mk_req(CMD_INSERT, 65, 1, 0));
    run_cmd(mk_req(CMD_DELETE, 64, 0, 0));
    run_cmd(mk_req(CMD_DELETE, 63, 0, 0));
    run_cmd(mk_req(CMD_INSERT, 63, 32'h7fff_ffff, 0));
    run_cmd(mk_req(CMD_SEARCH, 0, 32'h7fff_ffff, 0));
    // long receiver hold-off while the sender keeps offering
    recv_hold_cycles = 400;
    run_cmd(mk_req(CMD_DUMP, 0, 0, 0));
    for (int i = 0; i < 6; i++) run_cmd(mk_req(CMD_SEARCH, 0, rand_value(), 0));
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 27 : 0;
      for (int k = 0; k < 35; k++) begin
        n = list_q.size();
        req = rand_req(n, (k / 20) % 2 == 1);
        run_cmd(req);
      end
      drain();
    end

    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS array_list_engine");
    end else begin
      $display("FAIL array_list_engine");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/ale_pkg.sv
sv/ale_if.sv
sv/ale_ram.sv
sv/ale_datapath.sv
sv/ale_ctrl.sv
sv/array_list_engine.sv
dv/array_list_engine_test.sv
